[src/atl_pkg.sv]
// atl_pkg: shared constants, widths and the CORDIC arctangent table for the
// tilt angle pipeline. No dependencies.
package atl_pkg;

    localparam int CORDIC_MAX = 24;
    localparam int DAT_W      = 36;
    localparam int ACC_W      = 34;
    localparam int SQRT_STEPS = 32;
    localparam int PROD_W     = 50;

    localparam logic signed [ACC_W-1:0] QUARTER_TURN = 34'sh040000000;
    localparam logic [15:0]             CDEG_SCALE   = 16'd36000;
    localparam int                      ROLL_LIMIT   = 18000;
    localparam int                      PITCH_LIMIT  = 9000;

    function automatic logic signed [ACC_W-1:0] atan_turn(input int unsigned idx);
        logic signed [ACC_W-1:0] t;
        begin
            case (idx)
                0:  t = 34'sh020000000;
                1:  t = 34'sh012E4051E;
                2:  t = 34'sh009FB385B;
                3:  t = 34'sh0051111D4;
                4:  t = 34'sh0028B0D43;
                5:  t = 34'sh00145D7E1;
                6:  t = 34'sh000A2F61E;
                7:  t = 34'sh000517C55;
                8:  t = 34'sh00028BE53;
                9:  t = 34'sh000145F2F;
                10: t = 34'sh0000A2F98;
                11: t = 34'sh0000517CC;
                12: t = 34'sh000028BE6;
                13: t = 34'sh0000145F3;
                14: t = 34'sh000000A2FA;
                15: t = 34'sh00000517D;
                16: t = 34'sh0000028BE;
                17: t = 34'sh00000145F;
                18: t = 34'sh000000A30;
                19: t = 34'sh000000518;
                20: t = 34'sh00000028C;
                21: t = 34'sh000000146;
                22: t = 34'sh0000000A3;
                23: t = 34'sh000000051;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

endpackage

[src/accel_tilt_angles_top.sv]
// accel_tilt_angles_top: roll and pitch from one accelerometer sample.
// Depends on atl_pkg, atl_sqrt and atl_cordic.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  sample   | start high, busy low| i_stamp, i_accel_x, i_accel_y, i_accel_z
//  result   | o_valid, one cycle  | o_stamp_out, o_roll_cdeg, o_pitch_cdeg
//
// One sample enters every cycle; results leave in order, passing through 3
// input stages (input register, squares, sum), 32 square-root bit stages,
// 1 fold stage, one stage per CORDIC step (CORDIC_STEPS capped at 24) and 3
// conversion stages. busy is high only while reset is held; reset clears
// all valid bits. Nothing stalls: the receiver takes every result.
module accel_tilt_angles_top #(
    parameter int SAMPLE_BITS  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        i_stamp,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    output logic               o_valid,
    output logic [31:0]        o_stamp_out,
    output logic signed [15:0] o_roll_cdeg,
    output logic signed [14:0] o_pitch_cdeg
);
    localparam int FRAC  = 32 - SAMPLE_BITS;
    localparam int RW    = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int STEPS = (CORDIC_STEPS < atl_pkg::CORDIC_MAX) ?
                           CORDIC_STEPS : atl_pkg::CORDIC_MAX;
    localparam int DW    = atl_pkg::DAT_W;

    assign busy = ~i_rst_n;

    logic [RW-1:0] ext_x, ext_y, ext_z;
    assign ext_x = RW'($unsigned(i_accel_x));
    assign ext_y = RW'($unsigned(i_accel_y));
    assign ext_z = RW'($unsigned(i_accel_z));

    logic        r0_vld;
    logic [31:0] r0_stamp;
    logic signed [31:0] r0_x, r0_y, r0_z;

    always_ff @(posedge i_clk) begin
        r0_stamp <= i_stamp;
        r0_x     <= $signed({ext_x[SAMPLE_BITS-1:0], {FRAC{1'b0}}});
        r0_y     <= $signed({ext_y[SAMPLE_BITS-1:0], {FRAC{1'b0}}});
        r0_z     <= $signed({ext_z[SAMPLE_BITS-1:0], {FRAC{1'b0}}});
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= start & ~busy;
        end
    end

    logic [31:0] abs_y, abs_z;
    assign abs_y = r0_y[31] ? 32'(-r0_y) : 32'(r0_y);
    assign abs_z = r0_z[31] ? 32'(-r0_z) : 32'(r0_z);

    logic        r1_vld;
    logic [31:0] r1_stamp;
    logic signed [31:0] r1_x, r1_y;
    logic [63:0] r1_yy, r1_zz;

    always_ff @(posedge i_clk) begin
        r1_stamp <= r0_stamp;
        r1_x     <= r0_x;
        r1_y     <= r0_y;
        r1_yy    <= 64'(abs_y) * 64'(abs_y);
        r1_zz    <= 64'(abs_z) * 64'(abs_z);
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= r0_vld;
        end
    end

    logic        r2_vld;
    logic [95:0] r2_side;
    logic [63:0] r2_sum;

    always_ff @(posedge i_clk) begin
        r2_side <= {r1_stamp, r1_x, r1_y};
        r2_sum  <= r1_yy + r1_zz;
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    logic        sq_vld;
    logic [31:0] sq_root;
    logic [95:0] sq_side;

    atl_sqrt #(.SIDE_W(96)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_vld),
        .i_rad   (r2_sum),
        .i_side  (r2_side),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    logic signed [DW-1:0] roll_x, roll_y, pitch_x, pitch_y;
    assign roll_x  = DW'($signed(sq_side[63:32]));
    assign roll_y  = DW'($signed(sq_side[31:0]));
    assign pitch_y = -roll_x;
    assign pitch_x = $signed(DW'(sq_root));

    logic roll_vld, pitch_vld;

    atl_cordic #(
        .STEPS (STEPS),
        .LIMIT (atl_pkg::ROLL_LIMIT),
        .OUT_W (16),
        .SIDE_W(32)
    ) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_vld),
        .i_y     (roll_y),
        .i_x     (roll_x),
        .i_side  (sq_side[95:64]),
        .o_valid (roll_vld),
        .o_angle (o_roll_cdeg),
        .o_side  (o_stamp_out)
    );

    atl_cordic #(
        .STEPS (STEPS),
        .LIMIT (atl_pkg::PITCH_LIMIT),
        .OUT_W (15),
        .SIDE_W(1)
    ) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_vld),
        .i_y     (pitch_y),
        .i_x     (pitch_x),
        .i_side  (1'b0),
        .o_valid (pitch_vld),
        .o_angle (o_pitch_cdeg),
        .o_side  ()
    );

    assign o_valid = roll_vld & pitch_vld;
endmodule

[src/atl_sqrt.sv]
// atl_sqrt: pipelined floor square root of a 64-bit value, one root bit per
// stage, with a side payload carried in step. Depends on atl_pkg.
module atl_sqrt #(
    parameter int SIDE_W = 96
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [63:0]       i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [31:0]       o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int STEPS = atl_pkg::SQRT_STEPS;

    logic [63:0]       r_v    [STEPS];
    logic [63:0]       r_root [STEPS];
    logic [SIDE_W-1:0] r_side [STEPS];
    logic [STEPS-1:0]  r_vld;

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0]       cur_v, cur_root, trial, n_v, n_root;
        logic [SIDE_W-1:0] cur_side;
        logic              cur_vld;
        if (k == 0) begin : g_first
            assign cur_v    = i_rad;
            assign cur_root = '0;
            assign cur_side = i_side;
            assign cur_vld  = i_valid;
        end else begin : g_next
            assign cur_v    = r_v[k-1];
            assign cur_root = r_root[k-1];
            assign cur_side = r_side[k-1];
            assign cur_vld  = r_vld[k-1];
        end
        always_comb begin
            trial = cur_root + BIT;
            if (cur_v >= trial) begin
                n_v    = cur_v - trial;
                n_root = (cur_root >> 1) + BIT;
            end else begin
                n_v    = cur_v;
                n_root = cur_root >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            r_v[k]    <= n_v;
            r_root[k] <= n_root;
            r_side[k] <= cur_side;
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= cur_vld;
            end
        end
    end

    assign o_valid = r_vld[STEPS-1];
    assign o_root  = r_root[STEPS-1][31:0];
    assign o_side  = r_side[STEPS-1];
endmodule

[src/atl_cordic.sv]
// atl_cordic: pipelined CORDIC vectoring atan2 with quadrant fold, then
// conversion to hundredths of a degree with saturation. Depends on atl_pkg.
module atl_cordic #(
    parameter int STEPS  = 16,
    parameter int LIMIT  = 18000,
    parameter int OUT_W  = 16,
    parameter int SIDE_W = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [atl_pkg::DAT_W-1:0]    i_y,
    input  logic signed [atl_pkg::DAT_W-1:0]    i_x,
    input  logic [SIDE_W-1:0]                   i_side,
    output logic                                o_valid,
    output logic signed [OUT_W-1:0]             o_angle,
    output logic [SIDE_W-1:0]                   o_side
);
    localparam int DW = atl_pkg::DAT_W;
    localparam int AW = atl_pkg::ACC_W;
    localparam int PW = atl_pkg::PROD_W;

    // quadrant fold
    logic signed [DW-1:0] r_px, r_py;
    logic signed [AW-1:0] r_pacc;
    logic                 r_pzero, r_pvld;
    logic [SIDE_W-1:0]    r_pside;
    logic signed [DW-1:0] n_px, n_py;
    logic signed [AW-1:0] n_pacc;

    always_comb begin
        n_px   = i_x;
        n_py   = i_y;
        n_pacc = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_px   = i_y;
                n_py   = -i_x;
                n_pacc = atl_pkg::QUARTER_TURN;
            end else begin
                n_px   = -i_y;
                n_py   = i_x;
                n_pacc = -atl_pkg::QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_px    <= n_px;
        r_py    <= n_py;
        r_pacc  <= n_pacc;
        r_pzero <= (i_x == 0) && (i_y == 0);
        r_pside <= i_side;
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_valid;
        end
    end

    // rotation stages
    logic signed [DW-1:0] r_x    [STEPS];
    logic signed [DW-1:0] r_y    [STEPS];
    logic signed [AW-1:0] r_acc  [STEPS];
    logic                 r_zero [STEPS];
    logic [SIDE_W-1:0]    r_side [STEPS];
    logic [STEPS-1:0]     r_vld;

    for (genvar i = 0; i < STEPS; i++) begin : g_rot
        localparam logic signed [AW-1:0] ANG = atl_pkg::atan_turn(i);
        logic signed [DW-1:0] cx, cy, n_x, n_y;
        logic signed [AW-1:0] cacc, n_acc;
        logic                 czero, cvld;
        logic [SIDE_W-1:0]    cside;
        if (i == 0) begin : g_first
            assign cx = r_px;  assign cy = r_py;  assign cacc = r_pacc;
            assign czero = r_pzero;  assign cside = r_pside;  assign cvld = r_pvld;
        end else begin : g_next
            assign cx = r_x[i-1];  assign cy = r_y[i-1];  assign cacc = r_acc[i-1];
            assign czero = r_zero[i-1];  assign cside = r_side[i-1];
            assign cvld = r_vld[i-1];
        end
        always_comb begin
            if (cy >= 0) begin
                n_x   = cx + (cy >>> i);
                n_y   = cy - (cx >>> i);
                n_acc = cacc + ANG;
            end else begin
                n_x   = cx - (cy >>> i);
                n_y   = cy + (cx >>> i);
                n_acc = cacc - ANG;
            end
        end
        always_ff @(posedge i_clk) begin
            r_x[i]    <= n_x;
            r_y[i]    <= n_y;
            r_acc[i]  <= n_acc;
            r_zero[i] <= czero;
            r_side[i] <= cside;
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else begin
                r_vld[i] <= cvld;
            end
        end
    end

    // conversion: magnitude, scale, round and saturate
    logic [AW-1:0]     r_mag;
    logic              r_mneg, r_mzero, r_mvld;
    logic [SIDE_W-1:0] r_mside;
    logic signed [AW-1:0] fin_acc;

    assign fin_acc = r_acc[STEPS-1];

    always_ff @(posedge i_clk) begin
        r_mag   <= fin_acc[AW-1] ? AW'(-fin_acc) : AW'(fin_acc);
        r_mneg  <= fin_acc[AW-1];
        r_mzero <= r_zero[STEPS-1];
        r_mside <= r_side[STEPS-1];
        if (!i_rst_n) begin
            r_mvld <= 1'b0;
        end else begin
            r_mvld <= r_vld[STEPS-1];
        end
    end

    logic [PW-1:0]     r_prod;
    logic              r_qneg, r_qzero, r_qvld;
    logic [SIDE_W-1:0] r_qside;

    always_ff @(posedge i_clk) begin
        r_prod  <= PW'(r_mag) * PW'(atl_pkg::CDEG_SCALE);
        r_qneg  <= r_mneg;
        r_qzero <= r_mzero;
        r_qside <= r_mside;
        if (!i_rst_n) begin
            r_qvld <= 1'b0;
        end else begin
            r_qvld <= r_mvld;
        end
    end

    logic [PW-1:0]          rounded;
    logic [PW-33:0]         cdeg;
    logic [OUT_W-1:0]       sat;
    logic signed [OUT_W-1:0] n_angle;
    logic signed [OUT_W-1:0] r_angle;
    logic                   r_ovld;
    logic [SIDE_W-1:0]      r_oside;

    always_comb begin
        rounded = r_prod + (PW'(1) << 31);
        cdeg    = rounded[PW-1:32];
        if (cdeg > (PW-32)'(LIMIT)) begin
            sat = OUT_W'(LIMIT);
        end else begin
            sat = cdeg[OUT_W-1:0];
        end
        if (r_qzero) begin
            n_angle = '0;
        end else if (r_qneg) begin
            n_angle = -$signed(sat);
        end else begin
            n_angle = $signed(sat);
        end
    end

    always_ff @(posedge i_clk) begin
        r_angle <= n_angle;
        r_oside <= r_qside;
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_qvld;
        end
    end

    assign o_valid = r_ovld;
    assign o_angle = r_angle;
    assign o_side  = r_oside;
endmodule

[src/atl_checker.sv]
// atl_checker: port-level assertions for accel_tilt_angles_top, attached by
// bind. Depends on the top level's ports only.
module atl_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               busy,
    input logic               o_valid,
    input logic signed [15:0] o_roll_cdeg,
    input logic signed [14:0] o_pitch_cdeg
);
    a_busy_only_in_reset: assert property (@(posedge i_clk)
        i_rst_n |-> !busy) else $error("busy outside reset");

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result right after reset");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_cdeg >= -16'sd18000) && (o_roll_cdeg <= 16'sd18000))
        else $error("roll out of range");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_cdeg >= -15'sd9000) && (o_pitch_cdeg <= 15'sd9000))
        else $error("pitch out of range");
endmodule

bind accel_tilt_angles_top atl_checker u_atl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_roll_cdeg  (o_roll_cdeg),
    .o_pitch_cdeg (o_pitch_cdeg)
);
